/* design/mcsfd_pkg.sv */
// ----------------------------------------------------------------------------
// mcsfd_pkg
// Shared widths, codes, reset values and types for the motor channel block.
// ----------------------------------------------------------------------------
package mcsfd_pkg;

	localparam int unsigned CountW   = 15;
	localparam int unsigned CmdW     = 15;
	localparam int unsigned FwdW     = 14;
	localparam int unsigned RevW     = 15;
	localparam int unsigned FiltW    = 16;
	localparam int unsigned SmoothW  = 24;
	localparam int unsigned RunW     = 8;
	localparam int unsigned LimW     = 14;
	localparam int unsigned OvLimW   = 15;
	localparam int unsigned CfgDataW = 15;
	localparam int unsigned CfgIdxW  = 2;

	// Filter weights in Q8: 0.7 and 0.3 of the old and new value.
	localparam int unsigned WOld = 179;
	localparam int unsigned WNew = 77;

	// Item codes.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_CMD    = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		CFG_SPEED_LIMIT    = 2'd0,
		CFG_OVERSPEED_LIM  = 2'd1,
		CFG_FAULT_RUN_LEN  = 2'd2,
		CFG_FORWARD_LEVEL  = 2'd3
	} cfg_idx_t;

	localparam logic [LimW-1:0]   RstSpeedLimit = 14'd8000;
	localparam logic [OvLimW-1:0] RstOverLimit  = 15'd1000;
	localparam logic [RunW-1:0]   RstFaultRun   = 8'd10;
	localparam logic              RstFwdLevel   = 1'b0;

	// One item moving through the compute stage.
	typedef struct packed {
		logic fire;
		logic is_cmd;
	} step_t;

endpackage

/* design/mcsfd_filter.sv */
// ----------------------------------------------------------------------------
// mcsfd_filter
// Signed Q8 speed smoothing with overspeed compare.
// ----------------------------------------------------------------------------
module mcsfd_filter import mcsfd_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  step_t                    step,
	input  logic [CountW-1:0]        enc_count,
	input  logic                     dir_level,
	input  logic                     forward_level,
	input  logic [OvLimW-1:0]        overspeed_limit,
	output logic                     overspeed,
	output logic signed [FiltW-1:0]  filtered
);

	logic signed [SmoothW-1:0] smooth_q;
	logic signed [CountW:0]    cnt_signed;
	logic signed [32:0]        sum;
	logic signed [32:0]        sum_q8;
	logic signed [32:0]        sum_int;
	logic signed [SmoothW:0]   cur_int;
	logic [SmoothW-1:0]        smooth_abs;
	logic signed [SmoothW-1:0] smooth_next;

	always_comb begin
		cnt_signed = $signed({1'b0, enc_count});
		if (dir_level != forward_level) begin
			cnt_signed = -cnt_signed;
		end
		sum = 33'(smooth_q) * 33'sd179 + ((33'(cnt_signed) * 33'sd77) <<< 8);
		// Truncate toward zero: bias negative values before the shift.
		sum_q8  = (sum + (sum[32] ? 33'sd255 : 33'sd0)) >>> 8;
		sum_int = (sum + (sum[32] ? 33'sd65535 : 33'sd0)) >>> 16;
		smooth_next = sum_q8[SmoothW-1:0];
		cur_int = (25'(smooth_q) + (smooth_q[SmoothW-1] ? 25'sd255 : 25'sd0)) >>> 8;
		smooth_abs = smooth_q[SmoothW-1] ? SmoothW'(-smooth_q) : SmoothW'(smooth_q);
		overspeed = smooth_abs >= {1'b0, overspeed_limit, 8'h00};
		filtered = step.is_cmd ? cur_int[FiltW-1:0] : sum_int[FiltW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
		end else if (step.fire && !step.is_cmd) begin
			smooth_q <= smooth_next;
		end
	end

endmodule

/* design/mcsfd_drive.sv */
// ----------------------------------------------------------------------------
// mcsfd_drive
// Overspeed run counter, command clamp and sign-magnitude duty split.
// ----------------------------------------------------------------------------
module mcsfd_drive import mcsfd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  step_t                   step,
	input  logic signed [CmdW-1:0]  speed_cmd,
	input  logic                    overspeed,
	input  logic [LimW-1:0]         speed_limit,
	input  logic [RunW-1:0]         fault_run_length,
	output logic [FwdW-1:0]         fwd_duty,
	output logic [RevW-1:0]         rev_duty,
	output logic signed [CmdW-1:0]  applied_speed,
	output logic                    fault
);

	logic [RunW-1:0]    run_q;
	logic [FwdW-1:0]    last_fwd_q;
	logic [RevW-1:0]    last_rev_q;
	logic [RunW-1:0]    run_next;
	logic signed [15:0] cmd_w;
	logic signed [15:0] lim_w;
	logic signed [15:0] clamped;

	always_comb begin
		run_next = run_q;
		if (step.is_cmd) begin
			if (!overspeed) begin
				run_next = '0;
			end else if (run_q != '1) begin
				run_next = run_q + 1'b1;
			end
		end
		fault = run_next >= fault_run_length;

		cmd_w = 16'(speed_cmd);
		lim_w = $signed({2'b00, speed_limit});
		if (cmd_w >= lim_w) begin
			clamped = lim_w;
		end else if (cmd_w <= -lim_w) begin
			clamped = -lim_w;
		end else begin
			clamped = cmd_w;
		end

		if (!step.is_cmd) begin
			// Sample: repeat the drive left by the last command.
			fwd_duty      = last_fwd_q;
			rev_duty      = last_rev_q;
			applied_speed = $signed({1'b0, last_fwd_q} - last_rev_q);
		end else if (fault) begin
			fwd_duty      = '0;
			rev_duty      = '0;
			applied_speed = '0;
		end else begin
			fwd_duty      = clamped[15] ? '0 : clamped[FwdW-1:0];
			rev_duty      = clamped[15] ? RevW'(-clamped) : '0;
			applied_speed = clamped[CmdW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= '0;
			last_fwd_q <= '0;
			last_rev_q <= '0;
		end else if (step.fire && step.is_cmd) begin
			run_q      <= run_next;
			last_fwd_q <= fwd_duty;
			last_rev_q <= rev_duty;
		end
	end

endmodule

/* design/motor_channel_speed_filter_and_drive.sv */
// ----------------------------------------------------------------------------
// motor_channel_speed_filter_and_drive
// One motor channel: encoder speed smoothing, overspeed cutoff, H-bridge duty.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while in_ready is high and returns
// exactly one result beat for each input beat, in order. An accepted beat
// lands in the input register, passes the filter and drive logic and is
// loaded into the result register, from which it is offered, once that
// register is free or drains. Sustained rate is one item per cycle while
// the output does not stall; it is set by the state update of the smoothed
// speed and the run counter, which each item finishes before the next one
// enters the compute stage. Output stalls back up through the input
// register, and the input side keeps taking beats while the result register
// drains. Sample beats (op 0) update the smoothed speed and echo the last
// drive; command beats (op 1) update the overspeed run and set new
// forward/reverse duties. Configuration writes through
// cfg_we/cfg_index/cfg_wdata take effect at once and are meant to be made
// while no beat is in flight.
module motor_channel_speed_filter_and_drive import mcsfd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	// input channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       op,
	input  logic [CountW-1:0]          enc_count,
	input  logic                       dir_level,
	input  logic signed [CmdW-1:0]     speed_cmd,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [FwdW-1:0]            fwd_duty,
	output logic [RevW-1:0]            rev_duty,
	output logic signed [CmdW-1:0]     applied_speed,
	output logic                       fault,
	output logic signed [FiltW-1:0]    filtered_speed,
	// configuration
	input  logic                       cfg_we,
	input  logic [CfgIdxW-1:0]         cfg_index,
	input  logic [CfgDataW-1:0]        cfg_wdata
);

	// Configuration registers.
	logic [LimW-1:0]   speed_limit_q;
	logic [OvLimW-1:0] overspeed_limit_q;
	logic [RunW-1:0]   fault_run_len_q;
	logic              forward_level_q;

	// Input register.
	logic                   valid_s1;
	logic                   op_s1;
	logic [CountW-1:0]      enc_s1;
	logic                   dir_s1;
	logic signed [CmdW-1:0] cmd_s1;

	// Result register.
	logic                    valid_s2;
	logic [FwdW-1:0]         fwd_s2;
	logic [RevW-1:0]         rev_s2;
	logic signed [CmdW-1:0]  applied_s2;
	logic                    fault_s2;
	logic signed [FiltW-1:0] filt_s2;

	logic                    advance;
	logic                    in_fire;
	step_t                   step;
	logic                    overspeed;
	logic signed [FiltW-1:0] filt_c;
	logic [FwdW-1:0]         fwd_c;
	logic [RevW-1:0]         rev_c;
	logic signed [CmdW-1:0]  applied_c;
	logic                    fault_c;

	// Move the held beat forward whenever the result register is free or drains.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	assign step.fire   = advance;
	assign step.is_cmd = (op_s1 == OP_CMD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_limit_q     <= RstSpeedLimit;
			overspeed_limit_q <= RstOverLimit;
			fault_run_len_q   <= RstFaultRun;
			forward_level_q   <= RstFwdLevel;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SPEED_LIMIT:   speed_limit_q     <= cfg_wdata[LimW-1:0];
				CFG_OVERSPEED_LIM: overspeed_limit_q <= cfg_wdata[OvLimW-1:0];
				CFG_FAULT_RUN_LEN: fault_run_len_q   <= cfg_wdata[RunW-1:0];
				CFG_FORWARD_LEVEL: forward_level_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Input register: valid is control, payload loads only on accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1  <= op;
			enc_s1 <= enc_count;
			dir_s1 <= dir_level;
			cmd_s1 <= speed_cmd;
		end
	end

	mcsfd_filter u_filter (
		.clk             (clk),
		.arst_n          (arst_n),
		.step            (step),
		.enc_count       (enc_s1),
		.dir_level       (dir_s1),
		.forward_level   (forward_level_q),
		.overspeed_limit (overspeed_limit_q),
		.overspeed       (overspeed),
		.filtered        (filt_c)
	);

	mcsfd_drive u_drive (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.speed_cmd        (cmd_s1),
		.overspeed        (overspeed),
		.speed_limit      (speed_limit_q),
		.fault_run_length (fault_run_len_q),
		.fwd_duty         (fwd_c),
		.rev_duty         (rev_c),
		.applied_speed    (applied_c),
		.fault            (fault_c)
	);

	// Result register: hold until the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_s2     <= fwd_c;
			rev_s2     <= rev_c;
			applied_s2 <= applied_c;
			fault_s2   <= fault_c;
			filt_s2    <= filt_c;
		end
	end

	assign out_valid      = valid_s2;
	assign fwd_duty       = fwd_s2;
	assign rev_duty       = rev_s2;
	assign applied_speed  = applied_s2;
	assign fault          = fault_s2;
	assign filtered_speed = filt_s2;

endmodule

/* design/mcsfd_checker.sv */
// ----------------------------------------------------------------------------
// mcsfd_checker
// Port-level checks for the motor channel block, bound to the top level.
// ----------------------------------------------------------------------------
module mcsfd_checker import mcsfd_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    op,
	input logic [CountW-1:0]       enc_count,
	input logic                    dir_level,
	input logic signed [CmdW-1:0]  speed_cmd,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [FwdW-1:0]         fwd_duty,
	input logic [RevW-1:0]         rev_duty,
	input logic signed [CmdW-1:0]  applied_speed,
	input logic                    fault,
	input logic signed [FiltW-1:0] filtered_speed,
	input logic                    cfg_we,
	input logic [CfgIdxW-1:0]      cfg_index,
	input logic [CfgDataW-1:0]     cfg_wdata
);

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// Both bridge legs never drive at once.
	a_one_leg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fwd_duty == '0 || rev_duty == '0))
		else $error("forward and reverse duty both nonzero");

	// Applied speed always matches the duty pair.
	a_applied: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> applied_speed == $signed({1'b0, fwd_duty} - rev_duty))
		else $error("applied speed disagrees with duties");

	// The clamp keeps the reverse duty within the 14-bit limit range.
	a_rev_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !rev_duty[RevW-1])
		else $error("reverse duty beyond limit range");

endmodule

bind motor_channel_speed_filter_and_drive mcsfd_checker u_mcsfd_checker (.*);
